// File: hdl/sobel_energy_map_top_defines.svh
// Assertion macros for the top-level file, which checks its own logic.
// Each macro expands to one labelled concurrent assertion clocked on clk
// and disabled while rst_n is low.
`ifndef SOBEL_ENERGY_MAP_TOP_DEFINES_SVH
`define SOBEL_ENERGY_MAP_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobel energy map: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobel energy map: next-cycle check failed");

`endif

// File: hdl/sem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// Types, constants and helper functions of the gradient energy filter.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int PIX_W     = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 16;
  localparam int WID_W     = 12;
  localparam int KERN_W    = 36;
  localparam int CFG_W     = 36;
  localparam int IDX_W     = 2;
  localparam int TAP_W     = 4;
  localparam int SUM_W     = 16;
  localparam int SQ_W      = 2 * PIX_W + 1;
  localparam int ROOT_W    = 10;
  localparam int BIT_W     = 4;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  // Fixed-point luminance weights, scaled by 2^16.
  localparam logic [15:0] GRAY_R = 16'd19595;
  localparam logic [15:0] GRAY_G = 16'd38470;
  localparam logic [15:0] GRAY_B = 16'd7471;

  localparam logic [WID_W-1:0]  WIDTH_RST  = WID_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]  HEIGHT_RST = 16'd1080;
  localparam logic [KERN_W-1:0] KERN_X_RST = 36'd4548780303;
  localparam logic [KERN_W-1:0] KERN_Y_RST = 36'd4848619503;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERN_X = 2'd2,
    REG_KERN_Y = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_CONV,
    ST_SQUARE,
    ST_ROOT,
    ST_EMIT_A,
    ST_EMIT_B
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic conv;
    logic square;
    logic root_step;
    logic emit_a;
    logic emit_b;
  } cmd_t;

  typedef struct packed {
    logic emit_a;
    logic emit_b;
    logic root_last;
  } status_t;

  // Signed tap k of a packed kernel.
  function automatic logic signed [TAP_W-1:0] tap_of(input logic [KERN_W-1:0] kern,
                                                     input int k);
    tap_of = $signed(kern[TAP_W*k +: TAP_W]);
  endfunction

endpackage

// File: hdl/sem_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pix_if / sem_nrg_if
// Valid/ready channels for the incoming pixels and the outgoing energies.
// ----------------------------------------------------------------------------
interface sem_pix_if import sem_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface sem_nrg_if import sem_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] energy;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             last_of_frame;

  modport source (output valid, output energy, output out_col, output out_row,
                  output last_of_frame, input ready);
  modport sink   (input valid, input energy, input out_col, input out_row,
                  input last_of_frame, output ready);
endinterface

// File: hdl/sem_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-port RAM with a registered, read-first data output.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/sem_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer that steps one pixel through read, convolve, root and emit.
// ----------------------------------------------------------------------------
module sem_ctrl import sem_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_SHIFT;
      ST_SHIFT:  state_nxt = ST_CONV;
      ST_CONV: begin
        if (status.emit_a) state_nxt = ST_SQUARE;
        else if (status.emit_b) state_nxt = ST_EMIT_B;
        else state_nxt = ST_IDLE;
      end
      ST_SQUARE: state_nxt = ST_ROOT;
      ST_ROOT:   if (status.root_last) state_nxt = ST_EMIT_A;
      ST_EMIT_A: begin
        if (out_ready) state_nxt = status.emit_b ? ST_EMIT_B : ST_IDLE;
      end
      ST_EMIT_B: if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SHIFT:  cmd.shift = 1'b1;
      ST_CONV:   cmd.conv = 1'b1;
      ST_SQUARE: cmd.square = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_EMIT_A: begin
        out_valid  = 1'b1;
        cmd.emit_a = 1'b1;
      end
      ST_EMIT_B: begin
        out_valid  = 1'b1;
        cmd.emit_b = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/sem_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_dp
// Datapath: configuration, gray conversion, line stores, window, kernels,
// bit-serial square root and the raster counters.
// ----------------------------------------------------------------------------
module sem_dp import sem_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [PIX_W-1:0]  red,
  input  logic [PIX_W-1:0]  green,
  input  logic [PIX_W-1:0]  blue,
  input  cmd_t              cmd,
  output status_t           status,
  output logic [PIX_W-1:0]  energy,
  output logic [COL_W-1:0]  out_col,
  output logic [ROW_W-1:0]  out_row,
  output logic              last_of_frame
);

  logic [WID_W-1:0]  width_r;
  logic [ROW_W-1:0]  height_r;
  logic [KERN_W-1:0] kern_x_r, kern_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      kern_x_r <= KERN_X_RST;
      kern_y_r <= KERN_Y_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
        REG_KERN_X: kern_x_r <= cfg_data[KERN_W-1:0];
        REG_KERN_Y: kern_y_r <= cfg_data[KERN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes in use, saturated to their legal ranges.
  logic [WID_W-1:0] w_use;
  logic [ROW_W-1:0] h_use;
  always_comb begin
    if (width_r < WID_W'(3)) w_use = WID_W'(3);
    else if (width_r > WID_W'(MAX_WIDTH)) w_use = WID_W'(MAX_WIDTH);
    else w_use = width_r;
    h_use = (height_r < ROW_W'(3)) ? ROW_W'(3) : height_r;
  end

  logic [PIX_W-1:0] red_r, green_r, blue_r, gray_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
    end
    gray_r <= PIX_W'((GRAY_R * 26'(red_r) + GRAY_G * 26'(green_r)
                      + GRAY_B * 26'(blue_r)) >> 16);
  end

  logic [PIX_W-1:0] upper_q, middle_q;

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (cmd.shift),
    .addr  (col_r),
    .wdata (middle_q),
    .rdata (upper_q)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (cmd.shift),
    .addr  (col_r),
    .wdata (gray_r),
    .rdata (middle_q)
  );

  logic [PIX_W-1:0] win_r [9];

  logic row_end, frame_end;
  assign row_end   = {1'b0, col_r} >= (w_use - WID_W'(1));
  assign frame_end = row_end && (row_r >= h_use - ROW_W'(1));

  logic             emit_a_r, emit_b_r, calc_r, last_r;
  logic [COL_W-1:0] col_a_r, col_b_r;
  logic [ROW_W-1:0] rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
      col_r    <= '0;
      row_r    <= '0;
      emit_a_r <= 1'b0;
      emit_b_r <= 1'b0;
    end else if (cmd.shift) begin
      for (int j = 0; j < 3; j++) begin
        win_r[j*3]   <= win_r[j*3+1];
        win_r[j*3+1] <= win_r[j*3+2];
      end
      win_r[2] <= upper_q;
      win_r[5] <= middle_q;
      win_r[8] <= gray_r;
      emit_a_r <= (row_r != '0) && (col_r != '0);
      emit_b_r <= (row_r != '0) && row_end;
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      col_a_r <= col_r - COL_W'(1);
      col_b_r <= col_r;
      rr_r    <= row_r - ROW_W'(1);
      last_r  <= frame_end;
      calc_r  <= (row_r >= ROW_W'(2)) && (row_r <= h_use - ROW_W'(1))
                 && (col_r >= COL_W'(2)) && ({1'b0, col_r} <= w_use - WID_W'(1));
    end
  end

  // Kernel correlation, each sum clamped to the pixel range.
  logic signed [SUM_W-1:0] sum_x, sum_y;
  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int k = 0; k < 9; k++) begin
      sum_x = sum_x + SUM_W'($signed({1'b0, win_r[k]}) * tap_of(kern_x_r, k));
      sum_y = sum_y + SUM_W'($signed({1'b0, win_r[k]}) * tap_of(kern_y_r, k));
    end
  end

  function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] s);
    if (s < 0) clamp_pix = '0;
    else if (s > $signed(SUM_W'(PIX_MAX))) clamp_pix = PIX_MAX;
    else clamp_pix = s[PIX_W-1:0];
  endfunction

  logic [PIX_W-1:0] gx_r, gy_r;
  logic [SQ_W-1:0]  sq_r;
  logic [ROOT_W-1:0] root_r;
  logic [BIT_W-1:0]  bit_r;

  always_ff @(posedge clk) begin
    if (cmd.conv) begin
      gx_r <= clamp_pix(sum_x);
      gy_r <= clamp_pix(sum_y);
    end
  end

  // One result bit of the square root per cycle, most significant first.
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;
  assign trial    = root_r | (ROOT_W'(1) << bit_r);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_r   <= SQ_W'(gx_r * gx_r) + SQ_W'(gy_r * gy_r);
      root_r <= '0;
      bit_r  <= BIT_W'(ROOT_W - 1);
    end else if (cmd.root_step) begin
      if (trial_sq <= (2*ROOT_W)'(sq_r)) root_r <= trial;
      bit_r <= bit_r - BIT_W'(1);
    end
  end

  assign status.emit_a    = emit_a_r;
  assign status.emit_b    = emit_b_r;
  assign status.root_last = (bit_r == '0);

  always_comb begin
    energy        = '0;
    out_col       = col_b_r;
    out_row       = rr_r;
    last_of_frame = 1'b0;
    if (cmd.emit_a) begin
      out_col = col_a_r;
      if (calc_r) begin
        energy = (root_r > ROOT_W'(PIX_MAX)) ? PIX_MAX : root_r[PIX_W-1:0];
      end
    end else if (cmd.emit_b) begin
      last_of_frame = last_r;
    end
  end

endmodule

// File: hdl/sobel_energy_map_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_energy_map_top
// Streaming 3x3 gradient energy filter over an RGB raster.
// ----------------------------------------------------------------------------
// RGB pixels enter in raster order on in_ch, one word per valid/ready
// handshake. Each is turned into a gray level, pushed through two line
// stores and a 3x3 window, and correlated with two programmable kernels.
// Energies leave on out_ch, trailing the input by one row and one column;
// the first row of input produces no output, and the end of each row
// produces an extra, always-zero word for the right border pixel.
// The block works on one pixel at a time. A pixel that emits a computed
// word passes through accept, read, shift, convolve, square, ten
// square-root steps and emit, its time set chiefly by the bit-serial square
// root, plus an emit of the border word at a row end; a pixel that emits
// nothing stops after convolve. in_ch.ready is high only while the block is idle.
// Synchronous active-low reset returns the sizes and kernels to their
// defaults and clears the window and raster counters; the line stores are
// not cleared. When the receiver holds out_ch.ready low the word is held
// stable and no further pixel is taken. Configuration via cfg_we, cfg_index
// and cfg_data must only be written while the block is idle.
// ----------------------------------------------------------------------------
`include "sobel_energy_map_top_defines.svh"

module sobel_energy_map_top import sem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  sem_pix_if.sink          in_ch,
  sem_nrg_if.source        out_ch
);

  cmd_t    cmd;
  status_t status;

  // The sequencer owns both handshakes; the datapath only follows commands.
  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sem_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .red           (in_ch.red),
    .green         (in_ch.green),
    .blue          (in_ch.blue),
    .cmd           (cmd),
    .status        (status),
    .energy        (out_ch.energy),
    .out_col       (out_ch.out_col),
    .out_row       (out_ch.out_row),
    .last_of_frame (out_ch.last_of_frame)
  );

  // A result is never on offer while a new pixel could be taken.
  `SEM_ASSERT_IMP(a_no_overlap, out_ch.valid, !in_ch.ready)
  // After a pixel is taken the block is busy in the next cycle.
  `SEM_ASSERT_NXT(a_busy_after_take, in_ch.valid && in_ch.ready, !in_ch.ready)
  // The frame-end word is a border word and carries zero energy.
  `SEM_ASSERT_IMP(a_last_is_zero, out_ch.valid && out_ch.last_of_frame,
                  out_ch.energy == '0)

endmodule
